FILE: hdl/dcm_pkg.sv
// ----------------------------------------------------------------------------
// dcm_pkg: shared constants for the drive command mixer
// Command characters, register indexes, field widths and wheel limits.
// ----------------------------------------------------------------------------
package dcm_pkg;

  // Field widths
  localparam int CmdWidth   = 8;
  localparam int SpeedWidth = 7;
  localparam int ScaleWidth = 4;
  localparam int DutyWidth  = 10;
  localparam int TargWidth  = 8;
  localparam int CfgIdxWidth = 2;

  typedef logic [CmdWidth-1:0]   cmd_t;
  typedef logic [SpeedWidth-1:0] speed_t;
  typedef logic [ScaleWidth-1:0] scale_t;
  typedef logic [DutyWidth-1:0]  duty_t;
  typedef logic signed [TargWidth-1:0] target_t;

  // Command characters
  localparam cmd_t CmdFwd   = 8'h46;  // F
  localparam cmd_t CmdBack  = 8'h42;  // B
  localparam cmd_t CmdLeft  = 8'h4C;  // L
  localparam cmd_t CmdRight = 8'h52;  // R
  localparam cmd_t CmdStop  = 8'h53;  // S
  localparam cmd_t CmdZero  = 8'h30;  // 0
  localparam cmd_t CmdUp    = 8'h54;  // T
  localparam cmd_t CmdDown  = 8'h58;  // X
  localparam cmd_t CmdAuto  = 8'h41;  // A
  localparam cmd_t CmdPause = 8'h50;  // P
  localparam cmd_t CmdMan   = 8'h4D;  // M

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] RegSpeedStep  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegSpeedLimit = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegDutyScale  = 2'd2;

  // Reset values
  localparam speed_t ResetSpeed = 7'd50;
  localparam speed_t ResetStep  = 7'd10;
  localparam speed_t ResetLimit = 7'd100;
  localparam scale_t ResetScale = 4'd10;

  // Wheel and duty limits
  localparam speed_t WheelMax = 7'd100;
  localparam duty_t  DutyMax  = 10'd1000;

endpackage

FILE: hdl/drive_command_mixer.sv
// ----------------------------------------------------------------------------
// drive_command_mixer
// Decodes serial command bytes into drive targets and mixes them into
// left/right wheel direction and PWM duty values.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  cmd      | cmd_valid, cmd_stall, command_byte        | in
//  wheel    | wheel_valid, wheel_stall, left_*, right_*,| out
//           | speed_now                                 |
//  cfg      | cfg_write, cfg_index, cfg_data            | in
//
//  One byte per cycle sustained while the wheel channel does not stall. A
//  byte waits in the input register, then updates the state and loads the
//  result register as it moves on. Bytes that leave the block in auto mode
//  yield no result. rst (synchronous) restores manual mode, speed 50, zero
//  targets and the register defaults. A stall on the wheel channel holds
//  the result register and, once the input register is also full, raises
//  cmd_stall.
// ----------------------------------------------------------------------------
module drive_command_mixer (
  input  logic                            clk,
  input  logic                            rst,
  // command channel
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  dcm_pkg::cmd_t                   command_byte,
  // result channel
  output logic                            wheel_valid,
  input  logic                            wheel_stall,
  output logic                            left_reverse,
  output dcm_pkg::duty_t                  left_duty,
  output logic                            right_reverse,
  output dcm_pkg::duty_t                  right_duty,
  output dcm_pkg::speed_t                 speed_now,
  // configuration
  input  logic                            cfg_write,
  input  logic [dcm_pkg::CfgIdxWidth-1:0] cfg_index,
  input  dcm_pkg::speed_t                 cfg_data
);

  // Configuration registers
  dcm_pkg::speed_t speed_step;
  dcm_pkg::speed_t speed_limit;
  dcm_pkg::scale_t duty_scale;

  // Input register
  logic            cmd_held;
  dcm_pkg::cmd_t   cmd_reg;

  // Block state
  logic              auto_mode;
  dcm_pkg::speed_t   speed_setting;
  dcm_pkg::target_t  throttle_target;
  dcm_pkg::target_t  steering_target;

  logic              auto_mode_next;
  dcm_pkg::speed_t   speed_setting_next;
  dcm_pkg::target_t  throttle_target_next;
  dcm_pkg::target_t  steering_target_next;

  logic              advance;
  logic              speed_changed;
  logic [dcm_pkg::SpeedWidth:0] up_sum;
  dcm_pkg::target_t  speed_pos;
  dcm_pkg::target_t  speed_neg;

  logic              left_rev_next;
  logic              right_rev_next;
  dcm_pkg::duty_t    left_duty_next;
  dcm_pkg::duty_t    right_duty_next;
  logic signed [dcm_pkg::TargWidth:0] left_mix;
  logic signed [dcm_pkg::TargWidth:0] right_mix;

  // Saturate a mixed value to the wheel range and form its duty
  function automatic logic [dcm_pkg::DutyWidth:0] wheel_out(
    input logic signed [dcm_pkg::TargWidth:0] mix,
    input dcm_pkg::scale_t                    scale
  );
    logic                                  rev;
    logic [dcm_pkg::TargWidth:0]           abs_val;
    dcm_pkg::speed_t                       mag;
    logic [dcm_pkg::SpeedWidth+dcm_pkg::ScaleWidth-1:0] prod;
    dcm_pkg::duty_t                        duty;
    rev     = mix[dcm_pkg::TargWidth];
    abs_val = rev ? (~mix + 1'b1) : mix;
    if (abs_val > {2'b00, dcm_pkg::WheelMax}) begin
      mag = dcm_pkg::WheelMax;
    end else begin
      mag = abs_val[dcm_pkg::SpeedWidth-1:0];
    end
    prod = {{dcm_pkg::ScaleWidth{1'b0}}, mag} * {{dcm_pkg::SpeedWidth{1'b0}}, scale};
    if (prod > {1'b0, dcm_pkg::DutyMax}) begin
      duty = dcm_pkg::DutyMax;
    end else begin
      duty = prod[dcm_pkg::DutyWidth-1:0];
    end
    return {rev, duty};
  endfunction

  // Move the held byte on unless a finished result is waiting
  assign advance   = cmd_held && !(wheel_valid && wheel_stall);
  assign cmd_stall = cmd_held && !advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_step  <= dcm_pkg::ResetStep;
      speed_limit <= dcm_pkg::ResetLimit;
      duty_scale  <= dcm_pkg::ResetScale;
    end else if (cfg_write) begin
      case (cfg_index)
        dcm_pkg::RegSpeedStep:  speed_step  <= cfg_data;
        dcm_pkg::RegSpeedLimit: speed_limit <= cfg_data;
        dcm_pkg::RegDutyScale:  duty_scale  <= cfg_data[dcm_pkg::ScaleWidth-1:0];
        default: ;
      endcase
    end
  end

  // Capture the incoming byte
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_held <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      cmd_held <= 1'b1;
    end else if (advance) begin
      cmd_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      cmd_reg <= command_byte;
    end
  end

  // Decode the command into the next state
  always_comb begin
    auto_mode_next       = auto_mode;
    speed_setting_next   = speed_setting;
    throttle_target_next = throttle_target;
    steering_target_next = steering_target;
    speed_changed        = 1'b0;
    up_sum    = {1'b0, speed_setting} + {1'b0, speed_step};
    speed_pos = dcm_pkg::target_t'({1'b0, speed_setting});
    speed_neg = -speed_pos;
    case (cmd_reg)
      dcm_pkg::CmdFwd: begin
        auto_mode_next       = 1'b0;
        throttle_target_next = speed_pos;
        steering_target_next = '0;
      end
      dcm_pkg::CmdBack: begin
        auto_mode_next       = 1'b0;
        throttle_target_next = speed_neg;
        steering_target_next = '0;
      end
      dcm_pkg::CmdLeft: begin
        auto_mode_next       = 1'b0;
        throttle_target_next = '0;
        steering_target_next = speed_neg;
      end
      dcm_pkg::CmdRight: begin
        auto_mode_next       = 1'b0;
        throttle_target_next = '0;
        steering_target_next = speed_pos;
      end
      dcm_pkg::CmdStop, dcm_pkg::CmdZero, dcm_pkg::CmdPause, dcm_pkg::CmdMan: begin
        auto_mode_next       = 1'b0;
        throttle_target_next = '0;
        steering_target_next = '0;
      end
      dcm_pkg::CmdUp: begin
        speed_changed = 1'b1;
        if (up_sum > {1'b0, speed_limit}) begin
          speed_setting_next = speed_limit;
        end else begin
          speed_setting_next = up_sum[dcm_pkg::SpeedWidth-1:0];
        end
      end
      dcm_pkg::CmdDown: begin
        speed_changed = 1'b1;
        if (speed_step > speed_setting) begin
          speed_setting_next = '0;
        end else begin
          speed_setting_next = speed_setting - speed_step;
        end
      end
      dcm_pkg::CmdAuto: begin
        auto_mode_next = 1'b1;
      end
      default: ;
    endcase

    // Rescale a moving throttle to the new speed in manual mode, keeping its sign
    if (speed_changed && !auto_mode) begin
      if (throttle_target > 0) begin
        throttle_target_next = dcm_pkg::target_t'({1'b0, speed_setting_next});
      end else if (throttle_target < 0) begin
        throttle_target_next = -dcm_pkg::target_t'({1'b0, speed_setting_next});
      end
    end
  end

  // Mix throttle and steering into the two wheels
  always_comb begin
    left_mix  = {throttle_target_next[dcm_pkg::TargWidth-1], throttle_target_next}
              + {steering_target_next[dcm_pkg::TargWidth-1], steering_target_next};
    right_mix = {throttle_target_next[dcm_pkg::TargWidth-1], throttle_target_next}
              - {steering_target_next[dcm_pkg::TargWidth-1], steering_target_next};
    {left_rev_next, left_duty_next}   = wheel_out(left_mix, duty_scale);
    {right_rev_next, right_duty_next} = wheel_out(right_mix, duty_scale);
  end

  // Update the state as each byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_mode       <= 1'b0;
      speed_setting   <= dcm_pkg::ResetSpeed;
      throttle_target <= '0;
      steering_target <= '0;
    end else if (advance) begin
      auto_mode       <= auto_mode_next;
      speed_setting   <= speed_setting_next;
      throttle_target <= throttle_target_next;
      steering_target <= steering_target_next;
    end
  end

  // Result register: load in manual mode, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_valid <= 1'b0;
    end else if (advance && !auto_mode_next) begin
      wheel_valid <= 1'b1;
    end else if (!wheel_stall) begin
      wheel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !auto_mode_next) begin
      left_reverse  <= left_rev_next;
      left_duty     <= left_duty_next;
      right_reverse <= right_rev_next;
      right_duty    <= right_duty_next;
      speed_now     <= speed_setting_next;
    end
  end

  // Checks
  a_duty_limit: assert property (@(posedge clk) disable iff (rst)
    wheel_valid |-> (left_duty <= dcm_pkg::DutyMax && right_duty <= dcm_pkg::DutyMax))
    else $error("wheel duty above limit");

  a_one_target: assert property (@(posedge clk) disable iff (rst)
    (throttle_target != 0) |-> (steering_target == 0))
    else $error("throttle and steering both active");

  a_auto_silent: assert property (@(posedge clk) disable iff (rst)
    (advance && auto_mode_next) |=> !wheel_valid)
    else $error("result produced in auto mode");

endmodule
